// File: hdl/string_intern_pool_assert.svh
// Assertion macros shared by the string intern pool RTL.
// Each macro expects a clock and an active-low reset to be named by the caller.
`ifndef STRING_INTERN_POOL_ASSERT_SVH
`define STRING_INTERN_POOL_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIP_ASSERT_IMP(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SIP_ASSERT_NXT(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/sip_pkg.sv
// Package for the string intern pool: result status codes and controller states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sip_pkg;

	localparam int OFFSET_W = 10;
	localparam int STATUS_W = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND = 2'd0,
		ST_ADDED = 2'd1,
		ST_FULL  = 2'd2,
		ST_LONG  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_COPY,
		S_TERM
	} state_t;

endpackage

`default_nettype wire

// File: hdl/string_intern_pool.sv
// String intern pool: candidate buffer RAM, pool RAM and the scan/append controller.
// Depends on sip_pkg, sip_ram and string_intern_pool_assert.svh.
//
// Channel   Signals                        Handshake
// request   start, busy, char_byte         accepted when start && !busy
// result    done, entry_offset, status     one-cycle strobe on done, no stall
//
// A nonzero byte is written to the candidate RAM, or marks the request overlong
// once the candidate is full. A terminator scans up to fill_level pool bytes
// (one pool byte per cycle, read together with one candidate byte), and an append
// copies through the candidate RAM read port into the pool RAM write port.
// Overlong requests and an empty pool skip the scan. The result strobes in the
// cycle after the request completes; busy is high from the cycle after a scanned
// or appended terminator until that strobe.
// Reset clears the fill level and the candidate; the RAMs need no clearing.
`timescale 1ns / 1ps
`default_nettype none
`include "string_intern_pool_assert.svh"

module string_intern_pool #(
	parameter int POOL_BYTES = 1024,
	parameter int MAX_STRING = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [7:0]                   char_byte,
	output logic                              done,
	output logic [sip_pkg::OFFSET_W-1:0]      entry_offset,
	output logic [sip_pkg::STATUS_W-1:0]      status
);

	import sip_pkg::*;

	localparam int AW  = $clog2(POOL_BYTES);
	localparam int CAW = $clog2(MAX_STRING);
	localparam int KW  = $clog2(MAX_STRING + 1);
	localparam int SW  = ((AW > KW) ? AW : KW) + 1;

	state_t               state_q, state_d;
	logic [KW-1:0]        len_q, len_d;
	logic                 over_q, over_d;
	logic [AW-1:0]        fill_q, fill_d;
	logic [AW-1:0]        q_q, q_d;
	logic [AW-1:0]        start_q, start_d;
	logic [KW-1:0]        k_q, k_d;
	logic                 mism_q, mism_d;
	logic [KW-1:0]        rk_q, rk_d;
	logic                 cp_v_s1, cp_v_d;
	logic [KW-1:0]        cp_k_s1, cp_k_d;
	logic                 done_q, done_d;
	logic [OFFSET_W-1:0]  ofs_q, ofs_d;
	status_t              stat_q, stat_d;

	logic                 accept;
	logic                 fits;
	logic                 cand_we;
	logic [CAW-1:0]       cand_raddr;
	logic [7:0]           cand_rdata;
	logic                 pool_we;
	logic [AW-1:0]        pool_waddr;
	logic [7:0]           pool_wdata;
	logic [AW-1:0]        pool_raddr;
	logic [7:0]           pool_rdata;

	sip_ram #(.WIDTH(8), .DEPTH(MAX_STRING)) u_cand_ram (
		.clk   (clk),
		.we    (cand_we),
		.waddr (len_q[CAW-1:0]),
		.wdata (char_byte),
		.raddr (cand_raddr),
		.rdata (cand_rdata)
	);

	sip_ram #(.WIDTH(8), .DEPTH(POOL_BYTES)) u_pool_ram (
		.clk   (clk),
		.we    (pool_we),
		.waddr (pool_waddr),
		.wdata (pool_wdata),
		.raddr (pool_raddr),
		.rdata (pool_rdata)
	);

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// The string and its terminator must end below the last pool byte, so the new fill level stays within the pool.
	assign fits = (SW'(fill_q) + SW'(len_q) + SW'(1)) <= SW'(POOL_BYTES - 1);

	always_comb begin
		state_d    = state_q;
		len_d      = len_q;
		over_d     = over_q;
		fill_d     = fill_q;
		q_d        = q_q;
		start_d    = start_q;
		k_d        = k_q;
		mism_d     = mism_q;
		rk_d       = rk_q;
		cp_v_d     = 1'b0;
		cp_k_d     = cp_k_s1;
		done_d     = 1'b0;
		ofs_d      = ofs_q;
		stat_d     = stat_q;
		cand_we    = 1'b0;
		cand_raddr = '0;
		pool_raddr = '0;
		pool_we    = 1'b0;
		pool_waddr = AW'(SW'(fill_q) + SW'(cp_k_s1));
		pool_wdata = cand_rdata;

		// Copy data arrives in the cycle after its candidate read.
		if (cp_v_s1) begin
			pool_we = 1'b1;
		end

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (char_byte != 8'd0) begin
						if (len_q == KW'(MAX_STRING)) begin
							over_d = 1'b1;
						end else begin
							cand_we = 1'b1;
							len_d   = len_q + KW'(1);
						end
					end else if (over_q) begin
						done_d = 1'b1;
						ofs_d  = '0;
						stat_d = ST_LONG;
						len_d  = '0;
						over_d = 1'b0;
					end else if (fill_q == '0) begin
						if (fits) begin
							state_d = S_COPY;
							rk_d    = '0;
						end else begin
							done_d = 1'b1;
							ofs_d  = '0;
							stat_d = ST_FULL;
							len_d  = '0;
						end
					end else begin
						// Pool byte 0 and candidate byte 0 are read in this cycle.
						state_d = S_SCAN;
						q_d     = '0;
						start_d = '0;
						k_d     = '0;
						mism_d  = 1'b0;
					end
				end
			end
			S_SCAN: begin
				q_d        = q_q + AW'(1);
				pool_raddr = q_q + AW'(1);
				if (pool_rdata == 8'd0) begin
					if (!mism_q && (k_q == len_q)) begin
						state_d = S_IDLE;
						done_d  = 1'b1;
						ofs_d   = OFFSET_W'(start_q);
						stat_d  = ST_FOUND;
						len_d   = '0;
					end else if (q_q == fill_q - AW'(1)) begin
						if (fits) begin
							state_d = S_COPY;
							rk_d    = '0;
						end else begin
							state_d = S_IDLE;
							done_d  = 1'b1;
							ofs_d   = '0;
							stat_d  = ST_FULL;
							len_d   = '0;
						end
					end else begin
						start_d    = q_q + AW'(1);
						k_d        = '0;
						mism_d     = 1'b0;
						cand_raddr = '0;
					end
				end else begin
					if (!mism_q && (k_q != len_q) && (cand_rdata == pool_rdata)) begin
						k_d = k_q + KW'(1);
					end else begin
						mism_d = 1'b1;
					end
					cand_raddr = k_d[CAW-1:0];
				end
			end
			S_COPY: begin
				cand_raddr = rk_q[CAW-1:0];
				if (rk_q != len_q) begin
					rk_d   = rk_q + KW'(1);
					cp_v_d = 1'b1;
					cp_k_d = rk_q;
				end else begin
					state_d = S_TERM;
				end
			end
			S_TERM: begin
				pool_we    = 1'b1;
				pool_waddr = AW'(SW'(fill_q) + SW'(len_q));
				pool_wdata = 8'd0;
				fill_d     = AW'(SW'(fill_q) + SW'(len_q) + SW'(1));
				done_d     = 1'b1;
				ofs_d      = OFFSET_W'(fill_q);
				stat_d     = ST_ADDED;
				len_d      = '0;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			over_q  <= 1'b0;
			fill_q  <= '0;
			cp_v_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			over_q  <= over_d;
			fill_q  <= fill_d;
			cp_v_s1 <= cp_v_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		q_q     <= q_d;
		start_q <= start_d;
		k_q     <= k_d;
		mism_q  <= mism_d;
		rk_q    <= rk_d;
		cp_k_s1 <= cp_k_d;
		ofs_q   <= ofs_d;
		stat_q  <= stat_d;
	end

	assign done         = done_q;
	assign entry_offset = ofs_q;
	assign status       = stat_q;

	`SIP_ASSERT_IMP(a_fill_bound, clk, arst_n, 1'b1,
		SW'(fill_q) <= SW'(POOL_BYTES - 1), "fill level past pool end")
	`SIP_ASSERT_IMP(a_len_bound, clk, arst_n, 1'b1,
		len_q <= KW'(MAX_STRING), "candidate length past buffer")
	`SIP_ASSERT_IMP(a_scan_range, clk, arst_n, state_q == S_SCAN,
		q_q < fill_q, "scan ran past fill level")
	`SIP_ASSERT_IMP(a_pool_write, clk, arst_n, pool_we,
		state_q == S_COPY || state_q == S_TERM, "pool written outside append")
	`SIP_ASSERT_IMP(a_added_offset, clk, arst_n, done_q && stat_q == ST_ADDED,
		ofs_q == OFFSET_W'($past(fill_q)), "new entry not at old fill level")

endmodule

`default_nettype wire

// File: hdl/sip_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sip_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire
